>>> hw/rtl/rtc_pkg.sv
// Shared types, constants and calendar helpers for the real-time clock calendar.
package rtc_pkg;

  typedef enum logic [1:0] {
    OP_TICK       = 2'd0,
    OP_SET_TIME   = 2'd1,
    OP_SET_DATE   = 2'd2,
    OP_CLEAR_FLAG = 2'd3
  } opcode_t;

  typedef struct packed {
    opcode_t     opcode;
    logic [4:0]  set_hours;
    logic [5:0]  set_minutes;
    logic [5:0]  set_seconds;
    logic [4:0]  set_day;
    logic [3:0]  set_month;
    logic [11:0] set_year;
    logic [2:0]  set_weekday;
  } cmd_t;

  typedef struct packed {
    logic [4:0]  hour_now;
    logic [5:0]  minute_now;
    logic [5:0]  second_now;
    logic [4:0]  day_now;
    logic [3:0]  month_now;
    logic [11:0] year_now;
    logic [2:0]  weekday_now;
    logic        day_passed;
  } time_t;

  localparam logic [4:0]  LAST_HOUR     = 5'd23;
  localparam logic [5:0]  LAST_MINSEC   = 6'd59;
  localparam logic [2:0]  SUNDAY        = 3'd6;
  localparam logic [3:0]  MARCH_IDX     = 4'd2;
  localparam logic [3:0]  OCTOBER_IDX   = 4'd9;
  localparam logic [3:0]  DECEMBER_IDX  = 4'd11;
  localparam logic [4:0]  LAST_WEEK_IDX = 5'd24;
  localparam logic [4:0]  DST_LOW_HOUR  = 5'd2;
  localparam logic [4:0]  DST_HIGH_HOUR = 5'd3;
  localparam logic [11:0] RESET_YEAR    = 12'd2019;
  localparam logic [2:0]  RESET_WDAY    = 3'd1;
  localparam int          CENTURIES     = 41;  // multiples of 100 up to 4000

  // Gregorian leap year; year 0 counts as leap.
  function automatic logic is_leap(input logic [11:0] y);
    logic cent;
    logic quad_cent;
    cent      = 1'b0;
    quad_cent = 1'b0;
    for (int k = 0; k < CENTURIES; k++) begin
      if (y == 12'(k * 100)) begin
        cent = 1'b1;
        if ((k % 4) == 0) quad_cent = 1'b1;
      end
    end
    return (y[1:0] == 2'b00) && (!cent || quad_cent);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] mon_idx, input logic leap);
    logic [4:0] len;
    case (mon_idx)
      4'd1:                    len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

>>> hw/rtl/rtc_cmd_if.sv
// Command channel: valid/ready handshake carrying one clock command.
interface rtc_cmd_if;
  import rtc_pkg::*;
  logic valid;
  logic ready;
  cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/rtc_time_if.sv
// Result channel: valid/ready handshake carrying one time and date snapshot.
interface rtc_time_if;
  import rtc_pkg::*;
  logic  valid;
  logic  ready;
  time_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/rtc_calendar_with_dst.sv
// Top level: time-of-day and calendar counters with EU daylight saving, skid output.
//
//   channel | dir | payload | transaction
//   in_ch   | in  | cmd_t   | in_ch.valid & in_ch.ready
//   out_ch  | out | time_t  | out_ch.valid & out_ch.ready
//
// One command per cycle while in_ch.ready is high: the counters update in one pass
// and the snapshot after the update is registered in the output or skid register.
// A skid register behind the output register keeps in_ch.ready a plain flop, so a
// stalled output still lets one more command in before ready drops.
// Reset gives 00:00:00, Tuesday 1 January 2019, day-passed flag clear.
module rtc_calendar_with_dst (
  input  logic       clk,
  input  logic       rst_n,
  rtc_cmd_if.sink    in_ch,
  rtc_time_if.source out_ch
);
  import rtc_pkg::*;

  logic [4:0]  hour_r,  hour_nxt;
  logic [5:0]  min_r,   min_nxt;
  logic [5:0]  sec_r,   sec_nxt;
  logic [4:0]  day_r,   day_nxt;    // day of month, from 0
  logic [3:0]  mon_r,   mon_nxt;    // month, from 0
  logic [11:0] year_r,  year_nxt;
  logic [2:0]  wday_r,  wday_nxt;
  logic        armed_r, armed_nxt;  // fallback not yet taken today
  logic        flag_r,  flag_nxt;

  logic        out_valid_r, out_valid_nxt;
  time_t       out_data_r,  out_data_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  time_t       skid_data_r,  skid_data_nxt;

  logic        push;
  logic        rollover;
  logic        last_sunday;
  logic        at_top;      // mm:ss == 00:00
  time_t       result;
  cmd_t        cmd;

  assign cmd       = in_ch.data;
  assign in_ch.ready = !skid_valid_r;
  assign push      = in_ch.valid && !skid_valid_r;

  always_comb begin
    hour_nxt    = hour_r;
    min_nxt     = min_r;
    sec_nxt     = sec_r;
    day_nxt     = day_r;
    mon_nxt     = mon_r;
    year_nxt    = year_r;
    wday_nxt    = wday_r;
    armed_nxt   = armed_r;
    flag_nxt    = flag_r;
    rollover    = 1'b0;
    last_sunday = 1'b0;
    at_top      = 1'b0;
    if (push) begin
      unique case (cmd.opcode)
        OP_TICK: begin
          if (sec_r == LAST_MINSEC) begin
            sec_nxt = '0;
            if (min_r == LAST_MINSEC) begin
              min_nxt = '0;
              if (hour_r == LAST_HOUR) begin
                hour_nxt = '0;
                rollover = 1'b1;
              end else begin
                hour_nxt = hour_r + 5'd1;
              end
            end else begin
              min_nxt = min_r + 6'd1;
            end
          end else begin
            sec_nxt = sec_r + 6'd1;
          end
          if (rollover) begin
            wday_nxt  = (wday_r >= SUNDAY) ? 3'd0 : wday_r + 3'd1;
            flag_nxt  = 1'b1;
            armed_nxt = 1'b1;
            if ((day_r + 5'd1) >= month_len(mon_r, is_leap(year_r))) begin
              day_nxt = '0;
              if (mon_r >= DECEMBER_IDX) begin
                mon_nxt  = '0;
                year_nxt = year_r + 12'd1;
              end else begin
                mon_nxt = mon_r + 4'd1;
              end
            end else begin
              day_nxt = day_r + 5'd1;
            end
          end
          // DST checks see the date after any rollover
          last_sunday = (wday_nxt == SUNDAY) && (day_nxt >= LAST_WEEK_IDX);
          at_top      = (min_nxt == '0) && (sec_nxt == '0);
          if (last_sunday && at_top && mon_nxt == MARCH_IDX && hour_nxt == DST_LOW_HOUR) begin
            hour_nxt = DST_HIGH_HOUR;
          end else if (last_sunday && at_top && mon_nxt == OCTOBER_IDX &&
                       hour_nxt == DST_HIGH_HOUR && armed_nxt) begin
            hour_nxt  = DST_LOW_HOUR;
            armed_nxt = 1'b0;
          end
        end
        OP_SET_TIME: begin
          hour_nxt = (cmd.set_hours   > LAST_HOUR)   ? LAST_HOUR   : cmd.set_hours;
          min_nxt  = (cmd.set_minutes > LAST_MINSEC) ? LAST_MINSEC : cmd.set_minutes;
          sec_nxt  = (cmd.set_seconds > LAST_MINSEC) ? LAST_MINSEC : cmd.set_seconds;
        end
        OP_SET_DATE: begin
          day_nxt  = (cmd.set_day == '0) ? 5'd0 : cmd.set_day - 5'd1;
          mon_nxt  = (cmd.set_month == '0) ? 4'd0 :
                     (cmd.set_month > 4'd12) ? DECEMBER_IDX : cmd.set_month - 4'd1;
          year_nxt = cmd.set_year;
          wday_nxt = (cmd.set_weekday > SUNDAY) ? SUNDAY : cmd.set_weekday;
        end
        OP_CLEAR_FLAG: begin
          flag_nxt = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    result.hour_now    = hour_nxt;
    result.minute_now  = min_nxt;
    result.second_now  = sec_nxt;
    result.day_now     = day_nxt + 5'd1;
    result.month_now   = mon_nxt + 4'd1;
    result.year_now    = year_nxt;
    result.weekday_now = wday_nxt;
    result.day_passed  = flag_nxt;
  end

  // output register plus skid
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || out_ch.ready) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = push;
        out_data_nxt  = result;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = result;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hour_r       <= '0;
      min_r        <= '0;
      sec_r        <= '0;
      day_r        <= '0;
      mon_r        <= '0;
      year_r       <= RESET_YEAR;
      wday_r       <= RESET_WDAY;
      armed_r      <= 1'b1;
      flag_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      hour_r       <= hour_nxt;
      min_r        <= min_nxt;
      sec_r        <= sec_nxt;
      day_r        <= day_nxt;
      mon_r        <= mon_nxt;
      year_r       <= year_nxt;
      wday_r       <= wday_nxt;
      armed_r      <= armed_nxt;
      flag_r       <= flag_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

endmodule
